// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check macros used by the hash key set table top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/hks_pkg.sv =====
// ----------------------------------------------------------------------------
// hks_pkg
// Sizes, codes and control types of the hash key set table.
// ----------------------------------------------------------------------------
package hks_pkg;

  localparam int NUM_BUCKETS = 256;
  localparam int WAYS        = 4;
  localparam int KEY_W       = 32;
  localparam int CFG_W       = 9;
  localparam int CFG_RESET   = 256;
  localparam int STATUS_W    = 2;

  localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int CNT_W  = $clog2(NUM_BUCKETS + 1);
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int STEP_W = $clog2(KEY_W + 1);

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STS_CHECKED = 2'd0,
    STS_ADDED   = 2'd1,
    STS_ALREADY = 2'd2,
    STS_FULL    = 2'd3
  } rsp_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_EVAL
  } hks_state_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic rd;
    logic commit;
  } hks_cmd_t;

  typedef struct packed {
    logic div_done;
    logic clr_done;
  } hks_sts_t;

endpackage

// ===== src/hks_if.sv =====
// ----------------------------------------------------------------------------
// hks_req_if / hks_rsp_if
// Valid/ready channels for requests and responses of the key set table.
// ----------------------------------------------------------------------------
interface hks_req_if import hks_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [KEY_W-1:0] key;

  modport source (output valid, command, key, input ready);
  modport sink   (input valid, command, key, output ready);
endinterface

interface hks_rsp_if import hks_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                present;
  logic [STATUS_W-1:0] status;

  modport source (output valid, present, status, input ready);
  modport sink   (input valid, present, status, output ready);
endinterface

// ===== src/hash_key_set_table.sv =====
// ----------------------------------------------------------------------------
// hash_key_set_table
// Set of 32-bit keys in a bucketed table with WAYS slots per bucket.
//
//   Channel  Dir  Fields           Notes
//   req      in   command, key     add (0) or check (1) one key
//   rsp      out  present, status  one result per request
//   cfg      in   cfg_wdata        bucket count, written on cfg_we
//
// A request passes from its transfer to its result through the remainder unit,
// which retires one key bit per cycle, the step in which the controller sees it
// finish, the bucket read, and the compare and write. The table then returns to
// idle, and a new request is taken only there.
// After reset the valid memory is cleared one bucket per cycle, so no
// request is taken until every bucket is cleared.
// The result sits in an output register, and a new request is taken while it
// waits. A stalled result holds the next one in the compare step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hash_key_set_table import hks_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  hks_req_if.sink          req,
  hks_rsp_if.source        rsp
);

  hks_cmd_t cmd;
  hks_sts_t sts;

  hks_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hks_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .sts         (sts),
    .req_command (req.command),
    .req_key     (req.key),
    .rsp_present (rsp.present),
    .rsp_status  (rsp.status)
  );

  `ASSERT_NEXT(a_one_request_in_flight, clk, rst, req.valid && req.ready, !req.ready)
  `ASSERT_NEXT(a_commit_gives_result, clk, rst, cmd.commit, rsp.valid)
  `ASSERT_IMPLY(a_single_command, clk, rst, 1'b1, $onehot0({cmd.load, cmd.clr_step, cmd.rd, cmd.commit}))
  `ASSERT_IMPLY(a_no_request_while_clearing, clk, rst, cmd.clr_step, !req.ready)

endmodule

// ===== src/hks_div.sv =====
// ----------------------------------------------------------------------------
// hks_div
// Restoring remainder unit: one key bit per cycle, key modulo bucket count.
// ----------------------------------------------------------------------------
module hks_div import hks_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [BKT_W-1:0] remainder
);

  logic [STEP_W-1:0] cnt;
  logic [KEY_W-1:0]  shift;
  logic [BKT_W-1:0]  rem;
  logic [BKT_W:0]    trial;
  logic [BKT_W:0]    dvs;
  logic [BKT_W-1:0]  rem_next;

  always_comb begin
    trial = {rem, shift[KEY_W-1]};
    dvs   = (BKT_W + 1)'(divisor);
    if (trial >= dvs) begin
      rem_next = BKT_W'(trial - dvs);
    end else begin
      rem_next = BKT_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= STEP_W'(KEY_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift <= dividend;
      rem   <= '0;
    end else if (cnt != '0) begin
      shift <= {shift[KEY_W-2:0], 1'b0};
      rem   <= rem_next;
    end
  end

  assign done      = (cnt == '0);
  assign remainder = rem;

endmodule

// ===== src/hks_datapath.sv =====
// ----------------------------------------------------------------------------
// hks_datapath
// Bucket count register, key and valid memories, way compare and result.
// ----------------------------------------------------------------------------
module hks_datapath import hks_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_wdata,
  input  hks_cmd_t            cmd,
  output hks_sts_t            sts,
  input  logic                req_command,
  input  logic [KEY_W-1:0]    req_key,
  output logic                rsp_present,
  output logic [STATUS_W-1:0] rsp_status
);

  logic [CFG_W-1:0]           bucket_count;
  logic [CNT_W-1:0]           eff_count;
  logic                       cmd_q;
  logic [KEY_W-1:0]           key_q;
  logic [BKT_W-1:0]           bucket;
  logic [BKT_W-1:0]           clr_addr;
  logic                       div_done;
  logic                       clr_done;
  logic [WAYS-1:0][KEY_W-1:0] kmem [NUM_BUCKETS];
  logic [WAYS-1:0]            vmem [NUM_BUCKETS];
  logic [WAYS-1:0][KEY_W-1:0] krow;
  logic [WAYS-1:0]            vrow;
  logic                       hit;
  logic                       have_free;
  logic [WAY_W-1:0]           free_way;
  logic [WAYS-1:0]            way_mask;
  logic                       wr_en;
  rsp_status_t                status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= CFG_W'(CFG_RESET);
    end else if (cfg_we) begin
      bucket_count <= cfg_wdata;
    end
  end

  always_comb begin
    if (bucket_count == '0) begin
      eff_count = CNT_W'(1);
    end else if (32'(bucket_count) > NUM_BUCKETS) begin
      eff_count = CNT_W'(NUM_BUCKETS);
    end else begin
      eff_count = CNT_W'(bucket_count);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q <= req_command;
      key_q <= req_key;
    end
  end

  hks_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.load),
    .dividend  (req_key),
    .divisor   (eff_count),
    .done      (div_done),
    .remainder (bucket)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign clr_done = (clr_addr == BKT_W'(NUM_BUCKETS - 1));
  assign sts      = {div_done, clr_done};

  always_comb begin
    hit       = 1'b0;
    have_free = 1'b0;
    free_way  = '0;
    way_mask  = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (vrow[w]) begin
        if (krow[w] == key_q) begin
          hit = 1'b1;
        end
      end else if (!have_free) begin
        have_free   = 1'b1;
        free_way    = WAY_W'(w);
        way_mask[w] = 1'b1;
      end
    end
  end

  assign wr_en = cmd.commit && (cmd_q == CMD_ADD) && !hit && have_free;

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      krow <= kmem[bucket];
      vrow <= vmem[bucket];
    end
    if (wr_en) begin
      kmem[bucket][free_way] <= key_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      vmem[clr_addr] <= '0;
    end else if (wr_en) begin
      vmem[bucket] <= vrow | way_mask;
    end
  end

  always_comb begin
    if (cmd_q == CMD_CHECK) begin
      status_next = STS_CHECKED;
    end else if (hit) begin
      status_next = STS_ALREADY;
    end else if (have_free) begin
      status_next = STS_ADDED;
    end else begin
      status_next = STS_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_present <= hit;
      rsp_status  <= status_next;
    end
  end

endmodule

// ===== src/hks_ctrl.sv =====
// ----------------------------------------------------------------------------
// hks_ctrl
// Sequencer for clearing, remainder, bucket read and result transfer.
// ----------------------------------------------------------------------------
module hks_ctrl import hks_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  input  hks_sts_t sts,
  output hks_cmd_t cmd
);

  hks_state_t state;
  hks_state_t state_next;
  logic       out_valid;
  logic       out_free;

  assign out_free = !out_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      ST_READ: begin
        cmd.rd = 1'b1;
      end
      ST_EVAL: begin
        cmd.commit = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (rsp_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp_valid = out_valid;

endmodule
